[hdl/multi_servo_pulse_generator_top_defines.svh]
// Assertion macros shared by the servo pulse generator RTL.
// Every macro expects signals named clk and rst_n in the including scope.
`ifndef MULTI_SERVO_PULSE_GENERATOR_TOP_DEFINES_SVH
`define MULTI_SERVO_PULSE_GENERATOR_TOP_DEFINES_SVH

// Same-cycle implication, checked out of reset.
`define MSP_ASSERT_NOW(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define MSP_ASSERT_NEXT(label, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

[hdl/msp_pkg.sv]
// Package for the multi-channel servo pulse generator.
// Holds the request/result types, configuration bundle, codes and constants.
package msp_pkg;

  localparam int DEF_CHANNELS   = 6;
  localparam int DEF_WIDTH_BITS = 8;

  localparam int PHASE_BITS = 16;
  localparam int OUT_BITS   = 6;

  // Request function codes.
  localparam logic [1:0] FUNC_TICK  = 2'd0;
  localparam logic [1:0] FUNC_WRITE = 2'd1;
  localparam logic [1:0] FUNC_FLUSH = 2'd2;

  // Configuration register indexes.
  localparam logic [1:0] REG_MIN_PULSE = 2'd0;
  localparam logic [1:0] REG_MAX_PULSE = 2'd1;
  localparam logic [1:0] REG_GAP_TICKS = 2'd2;

  localparam logic [7:0]  MIN_RESET = 8'd16;
  localparam logic [7:0]  MAX_RESET = 8'd74;
  localparam logic [15:0] GAP_RESET = 16'd2400;

  // floor(x / 179) == (x * RECIP_179) >> RECIP_SHIFT for every x below 2^16.
  localparam int          RECIP_SHIFT = 24;
  localparam logic [16:0] RECIP_179   = 17'd93728;
  localparam int          DM_BITS     = 25;
  localparam logic [DM_BITS-1:0] DM_RESET =
    DM_BITS'(MAX_RESET - MIN_RESET) * DM_BITS'(RECIP_179);

  typedef struct packed {
    logic [1:0] func;
    logic [2:0] channel;
    logic [7:0] angle;
  } msp_in_t;

  typedef struct packed {
    logic [5:0] port_bits;
    logic       frame_start;
    logic       in_gap;
  } msp_out_t;

  // Configuration as seen by the datapath, with the span scale precomputed.
  typedef struct packed {
    logic [7:0]         lo;
    logic [7:0]         hi;
    logic [15:0]        gap;
    logic [7:0]         diff;
    logic [DM_BITS-1:0] dm;
    logic               up;
  } msp_cfg_t;

endpackage

[hdl/multi_servo_pulse_generator_top.sv]
// Multi-channel servo pulse generator, one request per clock while the output is not
// stalled, one result per request. Each request is turned into its result combinationally
// and the result is held in an output register; a new request is taken whenever that
// register is empty or being drained, so the sustained rate is one request per cycle and
// out_valid rises in the cycle after acceptance. Tick requests advance a frame of a
// 2^WIDTH_BITS-tick pulse window and a gap_ticks-tick low gap; write requests map an
// angle to a pulse width (one 8 by 25 bit multiply sets the path), flush requests
// schedule the copy of pending widths into the active table at the next gap start.
// Configuration writes are taken every cycle. Depends on msp_pkg and the msp_* submodules.
module multi_servo_pulse_generator_top
  import msp_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int WIDTH_BITS = DEF_WIDTH_BITS
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  msp_in_t     in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output msp_out_t    out_data,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  msp_cfg_t              cfg;
  logic [WIDTH_BITS-1:0] new_width;
  msp_out_t              result;
  logic                  in_acc;
  logic                  out_valid_r, out_valid_nxt;
  msp_out_t              out_data_r;

  assign cfg_ready = 1'b1;
  assign in_stall  = out_valid_r && out_stall;
  assign in_acc    = in_valid && !in_stall;

  msp_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  msp_angle_map #(
    .WIDTH_BITS (WIDTH_BITS)
  ) u_map (
    .angle (in_data.angle),
    .cfg   (cfg),
    .width (new_width)
  );

  msp_frame_core #(
    .CHANNELS   (CHANNELS),
    .WIDTH_BITS (WIDTH_BITS)
  ) u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_acc),
    .item      (in_data),
    .cfg       (cfg),
    .new_width (new_width),
    .result    (result)
  );

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (in_acc) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      out_data_r <= result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[hdl/msp_cfg_regs.sv]
// Configuration registers of the servo pulse generator.
// Depends on msp_pkg; also precomputes the pulse span scale for the angle map.
module msp_cfg_regs
  import msp_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        wr_en,
  input  logic [1:0]  wr_index,
  input  logic [15:0] wr_data,
  output msp_cfg_t    cfg
);

  logic [7:0]         min_r, min_nxt;
  logic [7:0]         max_r, max_nxt;
  logic [15:0]        gap_r, gap_nxt;
  logic [7:0]         diff_r, diff_nxt;
  logic [DM_BITS-1:0] dm_r, dm_nxt;
  logic               up_r, up_nxt;

  always_comb begin
    min_nxt = min_r;
    max_nxt = max_r;
    gap_nxt = gap_r;
    if (wr_en) begin
      unique case (wr_index)
        REG_MIN_PULSE: min_nxt = wr_data[7:0];
        REG_MAX_PULSE: max_nxt = wr_data[7:0];
        REG_GAP_TICKS: gap_nxt = wr_data;
        default: ;
      endcase
    end
    up_nxt   = (max_nxt >= min_nxt);
    diff_nxt = up_nxt ? (max_nxt - min_nxt) : (min_nxt - max_nxt);
    dm_nxt   = DM_BITS'(diff_nxt) * DM_BITS'(RECIP_179);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_r  <= MIN_RESET;
      max_r  <= MAX_RESET;
      gap_r  <= GAP_RESET;
      diff_r <= MAX_RESET - MIN_RESET;
      dm_r   <= DM_RESET;
      up_r   <= 1'b1;
    end else if (wr_en) begin
      min_r  <= min_nxt;
      max_r  <= max_nxt;
      gap_r  <= gap_nxt;
      diff_r <= diff_nxt;
      dm_r   <= dm_nxt;
      up_r   <= up_nxt;
    end
  end

  assign cfg = '{lo: min_r, hi: max_r, gap: gap_r, diff: diff_r, dm: dm_r, up: up_r};

endmodule

[hdl/msp_angle_map.sv]
// Angle to pulse width mapping with saturation at the full-angle width.
// Depends on msp_pkg for the configuration bundle and reciprocal constants.
module msp_angle_map
  import msp_pkg::*;
#(
  parameter int WIDTH_BITS = DEF_WIDTH_BITS
) (
  input  logic [7:0]            angle,
  input  msp_cfg_t              cfg,
  output logic [WIDTH_BITS-1:0] width
);

  localparam int PROD_BITS = DM_BITS + 8;

  logic [PROD_BITS-1:0] prod;
  logic [8:0]           quot;
  logic [9:0]           sum;
  logic [7:0]           w8;

  always_comb begin
    // Division by the angle span is a multiply by its reciprocal.
    prod = PROD_BITS'(angle) * PROD_BITS'(cfg.dm);
    quot = prod[PROD_BITS-1:RECIP_SHIFT];
    sum  = 10'(cfg.lo) + 10'(quot);
    if (cfg.up) begin
      w8 = (sum > 10'(cfg.hi)) ? cfg.hi : sum[7:0];
    end else begin
      w8 = (quot >= 9'(cfg.diff)) ? cfg.hi : (cfg.lo - quot[7:0]);
    end
    width = WIDTH_BITS'(w8);
  end

endmodule

[hdl/msp_frame_core.sv]
// Frame timing, width tables and channel levels of the servo pulse generator.
// Depends on msp_pkg and the assertion macros header.
`include "multi_servo_pulse_generator_top_defines.svh"

module msp_frame_core
  import msp_pkg::*;
#(
  parameter int CHANNELS   = DEF_CHANNELS,
  parameter int WIDTH_BITS = DEF_WIDTH_BITS
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  acc,
  input  msp_in_t               item,
  input  msp_cfg_t              cfg,
  input  logic [WIDTH_BITS-1:0] new_width,
  output msp_out_t              result
);

  localparam int WINDOW_TICKS = 2 ** WIDTH_BITS;
  localparam int PAD_BITS     = (CHANNELS > OUT_BITS) ? CHANNELS : OUT_BITS;

  logic [WIDTH_BITS-1:0] pend_r [CHANNELS];
  logic [WIDTH_BITS-1:0] act_r  [CHANNELS];
  logic                  upd_r, upd_nxt;
  logic [PHASE_BITS-1:0] phase_r, phase_nxt;
  logic                  gap_r, gap_nxt;
  logic [CHANNELS-1:0]   lvl_r, lvl_nxt;

  logic                  tick, wr, flush;
  logic                  win_last, gap_last, copy;
  logic [15:0]           gap_len;
  logic [CHANNELS-1:0]   lvl_win;
  logic [PAD_BITS-1:0]   lvl_pad;

  always_comb begin
    tick  = acc && (item.func == FUNC_TICK);
    wr    = acc && (item.func == FUNC_WRITE);
    flush = acc && (item.func == FUNC_FLUSH);

    win_last = (phase_r == PHASE_BITS'(WINDOW_TICKS - 1));
    gap_len  = (cfg.gap == 16'd0) ? 16'd1 : cfg.gap;
    // A gap shortened while counting ends as soon as the count passes it.
    gap_last = ((17'(phase_r) + 17'd1) >= 17'(gap_len));
    copy     = tick && !gap_r && win_last && upd_r;

    for (int n = 0; n < CHANNELS; n++) begin
      lvl_win[n] = (act_r[n] != '0) && (phase_r < PHASE_BITS'(act_r[n]));
    end

    upd_nxt   = upd_r;
    phase_nxt = phase_r;
    gap_nxt   = gap_r;
    lvl_nxt   = lvl_r;
    if (flush) begin
      upd_nxt = 1'b1;
    end
    if (tick) begin
      if (!gap_r) begin
        lvl_nxt = lvl_win;
        if (win_last) begin
          gap_nxt   = 1'b1;
          phase_nxt = '0;
          if (upd_r) begin
            upd_nxt = 1'b0;
          end
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end else begin
        lvl_nxt = '0;
        if (gap_last) begin
          gap_nxt   = 1'b0;
          phase_nxt = '0;
        end else begin
          phase_nxt = phase_r + 1'b1;
        end
      end
    end

    lvl_pad            = PAD_BITS'(lvl_nxt);
    result.port_bits   = lvl_pad[OUT_BITS-1:0];
    result.frame_start = tick && !gap_r && (phase_r == '0);
    result.in_gap      = gap_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      upd_r   <= 1'b0;
      phase_r <= '0;
      gap_r   <= 1'b0;
      lvl_r   <= '0;
      for (int n = 0; n < CHANNELS; n++) begin
        pend_r[n] <= WIDTH_BITS'(MIN_RESET);
        act_r[n]  <= '0;
      end
    end else begin
      upd_r   <= upd_nxt;
      phase_r <= phase_nxt;
      gap_r   <= gap_nxt;
      lvl_r   <= lvl_nxt;
      for (int n = 0; n < CHANNELS; n++) begin
        if (wr && (5'(item.channel) == 5'(n))) begin
          pend_r[n] <= new_width;
        end
        if (copy) begin
          act_r[n] <= pend_r[n];
        end
      end
    end
  end

  `MSP_ASSERT_NEXT(a_window_to_gap, tick && !gap_r && win_last,
                   gap_r && (phase_r == '0), "window end did not open the gap")
  `MSP_ASSERT_NEXT(a_update_consumed, copy, !upd_r,
                   "update request survived the copy to the active table")
  `MSP_ASSERT_NOW(a_window_bound, !gap_r, 32'(phase_r) < WINDOW_TICKS,
                  "window count ran past the window length")
  `MSP_ASSERT_NEXT(a_gap_low, tick && gap_r, lvl_r == '0,
                   "channel levels high after a gap tick")

endmodule

[tb/multi_servo_pulse_generator_top_tb.sv]
// Self-checking testbench for the six-channel servo pulse generator.
// Predicts every result from its own frame and width-table model; uses msp_pkg.
module multi_servo_pulse_generator_top_tb;
  import msp_pkg::*;

  localparam int          NUM_CH       = DEF_CHANNELS;
  localparam int          WINDOW_LEN   = 1 << DEF_WIDTH_BITS;
  localparam int          ANGLE_SPAN   = 179;
  localparam int          ANGLE_FULL   = 255;
  localparam logic [1:0]  FUNC_IGNORED = 2'd3;
  localparam logic [1:0]  REG_SPARE    = 2'd3;
  localparam int          PHASE_ITEMS  = 205;
  localparam int          RANDOM_PHASES = 7;

  logic     clk = 1'b0;
  logic     rst_n = 1'b0;
  logic     in_valid = 1'b0;
  logic     in_stall;
  msp_in_t  in_data = '0;
  logic     out_valid;
  logic     out_stall = 1'b0;
  msp_out_t out_data;
  logic     cfg_valid = 1'b0;
  logic     cfg_ready;
  logic [1:0]  cfg_index = REG_MIN_PULSE;
  logic [15:0] cfg_data = '0;

  multi_servo_pulse_generator_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
    .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Predicted block state and register copies.
  logic [7:0]  pend_width [NUM_CH];
  logic [7:0]  act_width [NUM_CH];
  bit          update_pending;
  int unsigned phase_cnt;
  bit          gap_active;
  logic [5:0]  level_bits;
  logic [7:0]  min_width;
  logic [7:0]  max_width;
  logic [15:0] gap_len;

  msp_out_t expected_levels [$];
  int       errors = 0;
  bit       idle_on = 1'b0;
  int       hold_cycles_req = 0;
  int       hold_left = 0;
  int       burst_left = 0;

  function automatic logic [7:0] angle_width(input logic [7:0] angle);
    int unsigned lo, hi, a, w, drop;
    lo = min_width;
    hi = max_width;
    a  = angle;
    if (hi >= lo) begin
      w = lo + (a * (hi - lo)) / ANGLE_SPAN;
      if (w > hi) w = hi;
    end else begin
      // Descending map: width falls from min toward max and stops there.
      drop = (a * (lo - hi)) / ANGLE_SPAN;
      w = (drop >= lo - hi) ? hi : lo - drop;
    end
    return w[7:0];
  endfunction

  function automatic msp_out_t frame_result(input msp_in_t req);
    msp_out_t    r;
    logic [5:0]  lv;
    int unsigned len;
    r = '0;
    if (req.func == FUNC_TICK) begin
      if (!gap_active) begin
        r.frame_start = (phase_cnt == 0);
        lv = '0;
        for (int n = 0; n < NUM_CH; n++)
          if (act_width[n] != 0 && phase_cnt < act_width[n]) lv[n] = 1'b1;
        level_bits = lv;
        phase_cnt++;
        if (phase_cnt >= WINDOW_LEN) begin
          gap_active = 1'b1;
          phase_cnt = 0;
          if (update_pending) begin
            act_width = pend_width;
            update_pending = 1'b0;
          end
        end
        r.in_gap = 1'b0;
      end else begin
        len = (gap_len == 0) ? 1 : gap_len;
        level_bits = '0;
        r.in_gap = 1'b1;
        phase_cnt++;
        if (phase_cnt >= len) begin
          gap_active = 1'b0;
          phase_cnt = 0;
        end
      end
      r.port_bits = level_bits;
    end else begin
      if (req.func == FUNC_WRITE && req.channel < NUM_CH)
        pend_width[req.channel] = angle_width(req.angle);
      else if (req.func == FUNC_FLUSH)
        update_pending = 1'b1;
      r.port_bits = level_bits;
      r.frame_start = 1'b0;
      r.in_gap = gap_active;
    end
    return r;
  endfunction

  function automatic void reset_servo_state();
    min_width = MIN_RESET;
    max_width = MAX_RESET;
    gap_len = GAP_RESET;
    for (int n = 0; n < NUM_CH; n++) begin
      pend_width[n] = MIN_RESET;
      act_width[n] = '0;
    end
    update_pending = 1'b0;
    phase_cnt = 0;
    gap_active = 1'b0;
    level_bits = '0;
  endfunction

  function automatic msp_in_t make_request(input logic [1:0] func, input int chan,
                                           input int angle);
    msp_in_t r;
    r.func = func;
    r.channel = chan[2:0];
    r.angle = angle[7:0];
    return r;
  endfunction

  // Called at a rising edge; returns at the edge where the request is taken.
  task automatic send_request(input msp_in_t req);
    int pause;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      pause = $urandom_range(1, 17);
      in_valid <= 1'b0;
      repeat (pause) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    do @(posedge clk); while (in_stall);
    expected_levels.push_back(frame_result(req));
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_levels.size() != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_MIN_PULSE: min_width = val[7:0];
      REG_MAX_PULSE: max_width = val[7:0];
      REG_GAP_TICKS: gap_len = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  always @(posedge clk) begin
    msp_out_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_levels.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        errors++;
      end else begin
        want = expected_levels.pop_front();
        if (out_data.port_bits !== want.port_bits) begin
          $display("%0t: port_bits expected %h actual %h", $time,
                   want.port_bits, out_data.port_bits);
          errors++;
        end
        if (out_data.frame_start !== want.frame_start) begin
          $display("%0t: frame_start expected %b actual %b", $time,
                   want.frame_start, out_data.frame_start);
          errors++;
        end
        if (out_data.in_gap !== want.in_gap) begin
          $display("%0t: in_gap expected %b actual %b", $time,
                   want.in_gap, out_data.in_gap);
          errors++;
        end
      end
    end
  end

  // Result-side stall: random bursts, plus a long hold when a test asks for one.
  always @(posedge clk) begin
    if (hold_cycles_req > 0) begin
      hold_left = hold_cycles_req;
      hold_cycles_req = 0;
    end
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else if (burst_left > 0) begin
      out_stall <= 1'b1;
      burst_left--;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      burst_left = $urandom_range(0, 16);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  task automatic test_angle_writes();
    send_request(make_request(FUNC_TICK, 0, 0));
    send_request(make_request(FUNC_WRITE, 0, 0));
    send_request(make_request(FUNC_WRITE, 1, ANGLE_SPAN));
    send_request(make_request(FUNC_WRITE, 2, ANGLE_FULL));
    send_request(make_request(FUNC_WRITE, 3, 90));
    send_request(make_request(FUNC_WRITE, 4, 1));
    send_request(make_request(FUNC_WRITE, 5, 178));
    // Channels six and seven do not exist and must leave the table alone.
    send_request(make_request(FUNC_WRITE, 6, 200));
    send_request(make_request(FUNC_WRITE, 7, ANGLE_FULL));
    send_request(make_request(FUNC_IGNORED, 7, ANGLE_FULL));
    send_request(make_request(FUNC_FLUSH, 0, 0));
    send_request(make_request(FUNC_TICK, 0, 0));
    wait_drained();
  endtask

  task automatic test_mapping_extremes();
    // Descending map with junk in the unused upper data bits.
    write_reg(REG_MIN_PULSE, 16'hFFFF);
    write_reg(REG_MAX_PULSE, 16'hFF00);
    write_reg(REG_SPARE, 16'hA5A5);
    send_request(make_request(FUNC_WRITE, 0, 0));
    send_request(make_request(FUNC_WRITE, 1, 90));
    send_request(make_request(FUNC_WRITE, 2, ANGLE_FULL));
    wait_drained();
    write_reg(REG_MIN_PULSE, 16'd0);
    write_reg(REG_MAX_PULSE, 16'd255);
    send_request(make_request(FUNC_WRITE, 3, ANGLE_SPAN));
    send_request(make_request(FUNC_WRITE, 4, ANGLE_FULL));
    send_request(make_request(FUNC_WRITE, 5, 0));
    wait_drained();
    write_reg(REG_MIN_PULSE, 16'd100);
    write_reg(REG_MAX_PULSE, 16'd100);
    send_request(make_request(FUNC_WRITE, 0, 37));
    send_request(make_request(FUNC_FLUSH, 0, 0));
    wait_drained();
  endtask

  task automatic test_gap_shortened();
    write_reg(REG_GAP_TICKS, 16'hFFFF);
    while (!(gap_active && phase_cnt >= 5))
      send_request(make_request(FUNC_TICK, 0, 0));
    wait_drained();
    // The count is already past the new length, so the next tick ends the gap.
    write_reg(REG_GAP_TICKS, 16'd3);
    repeat (3) send_request(make_request(FUNC_TICK, 0, 0));
    wait_drained();
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    hold_cycles_req = 60;
    repeat (40) send_request(make_request(FUNC_TICK, 0, 0));
    wait_drained();
  endtask

  task automatic random_config();
    case ($urandom_range(0, 3))
      0: begin
        write_reg(REG_MIN_PULSE, {8'($urandom_range(0, 255)), 8'd0});
        write_reg(REG_MAX_PULSE, 16'd255);
      end
      1: begin
        write_reg(REG_MIN_PULSE, 16'd255);
        write_reg(REG_MAX_PULSE, 16'($urandom_range(0, 65535)) & 16'hFF00);
      end
      2: begin
        write_reg(REG_MIN_PULSE, 16'(MIN_RESET));
        write_reg(REG_MAX_PULSE, 16'(MAX_RESET));
      end
      default: begin
        write_reg(REG_MIN_PULSE, 16'($urandom_range(0, 65535)));
        write_reg(REG_MAX_PULSE, 16'($urandom_range(0, 65535)));
      end
    endcase
    case ($urandom_range(0, 3))
      0: write_reg(REG_GAP_TICKS, 16'd0);
      1: write_reg(REG_GAP_TICKS, 16'd1);
      default: write_reg(REG_GAP_TICKS, 16'($urandom_range(2, 60)));
    endcase
  endtask

  function automatic int random_angle();
    case ($urandom_range(0, 7))
      0: return 0;
      1: return ANGLE_SPAN;
      2: return $urandom_range(ANGLE_SPAN + 1, ANGLE_FULL);
      default: return $urandom_range(0, ANGLE_SPAN);
    endcase
  endfunction

  task automatic test_random_frames();
    int sent;
    int pick;
    for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
      random_config();
      idle_on = (ph != RANDOM_PHASES - 1) && ($urandom_range(0, 3) != 0);
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(0, 99);
        if (pick < 3) begin
          // A complete servo update: new angles for every channel, then flush.
          for (int n = 0; n < NUM_CH; n++)
            send_request(make_request(FUNC_WRITE, n, random_angle()));
          send_request(make_request(FUNC_FLUSH, $urandom_range(0, 7), $urandom_range(0, 255)));
          sent += NUM_CH + 1;
        end else if (pick < 81) begin
          send_request(make_request(FUNC_TICK, $urandom_range(0, 7), $urandom_range(0, 255)));
          sent++;
        end else if (pick < 93) begin
          send_request(make_request(FUNC_WRITE,
                       ($urandom_range(0, 9) == 0) ? $urandom_range(6, 7)
                                                   : $urandom_range(0, 5),
                       random_angle()));
          sent++;
        end else if (pick < 97) begin
          send_request(make_request(FUNC_FLUSH, $urandom_range(0, 7), $urandom_range(0, 255)));
          sent++;
        end else begin
          send_request(make_request(FUNC_IGNORED, $urandom_range(0, 7),
                                    $urandom_range(0, 255)));
          sent++;
        end
      end
      wait_drained();
    end
  endtask

  initial begin
    reset_servo_state();
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_angle_writes();
    test_mapping_extremes();
    test_gap_shortened();
    test_backpressure();
    test_random_frames();
    if (errors == 0)
      $display("DONE: 0 errors");
    else
      $display("DONE: errors detected");
    $finish;
  end

  initial begin
    #8000000;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
